// File: rtl/core/bvlc_pkg.sv
// ----------------------------------------------------------------------------
// bvlc_pkg
// Shared widths, fixed-point calibration constants and stage structs for the
// battery voltage level calibrator.
// ----------------------------------------------------------------------------
package bvlc_pkg;

  // sample and register widths
  localparam int SAMPLE_BITS = 12;
  localparam int RES_W       = 24;
  localparam int LVL_W       = 17;
  localparam int MV_W        = 13;
  localparam int WDATA_W     = 24;

  // adc voltage in Q16 mV
  localparam int V_W    = SAMPLE_BITS + RES_W;
  // operand width after saturation at 8192 mV
  localparam int VOP_W  = 30;
  // quadratic segment operand width (below 4096 mV)
  localparam int VSQ_W  = 28;
  localparam int GAIN_W = 26;
  localparam int KSQ_W  = 13;
  localparam int SQ_W   = 2 * VSQ_W - 16;
  localparam int LIN_W  = GAIN_W + VOP_W;
  localparam int SQT_W  = KSQ_W + SQ_W;
  localparam int OFF_W  = 52;
  localparam int ACC_W  = LIN_W + 2;

  // register indexes
  localparam logic REG_RESOLUTION = 1'b0;
  localparam logic REG_CRITICAL   = 1'b1;

  localparam logic [RES_W-1:0] RESOLUTION_RST = RES_W'(52814);
  localparam logic [LVL_W-1:0] CRITICAL_RST   = LVL_W'(6554);

  // segment limits and saturation in Q16 mV
  localparam logic [V_W-1:0] SEG_LO_Q16 = V_W'(64'd2250 << 16);
  localparam logic [V_W-1:0] SEG_HI_Q16 = V_W'(64'd2901 << 16);
  localparam logic [V_W-1:0] V_SAT_Q16  = V_W'(64'd8192 << 16);

  // gains rounded half up to Q24
  localparam logic [GAIN_W-1:0] K1_GAIN =
    GAIN_W'((64'd12884270620 * 64'd16777216 + 64'd5000000000) / 64'd10000000000);
  localparam logic [GAIN_W-1:0] K2_LIN =
    GAIN_W'((64'd26595058150 * 64'd16777216 + 64'd5000000000) / 64'd10000000000);
  localparam logic [GAIN_W-1:0] K3_GAIN =
    GAIN_W'((64'd10356739640 * 64'd16777216 + 64'd5000000000) / 64'd10000000000);
  localparam logic [KSQ_W-1:0] K2_SQ =
    KSQ_W'((64'd3064030 * 64'd16777216 + 64'd5000000000) / 64'd10000000000);

  // offsets rounded half up to Q24, then moved to Q40
  localparam logic [OFF_W-1:0] K1_OFF_Q40 =
    OFF_W'(((64'd1126195281 * 64'd16777216 + 64'd5000000) / 64'd10000000) << 16);
  localparam logic [OFF_W-1:0] K2_OFF_Q40 =
    OFF_W'(((64'd14366059690 * 64'd16777216 + 64'd5000000) / 64'd10000000) << 16);
  localparam logic [OFF_W-1:0] K3_OFF_Q40 =
    OFF_W'(((64'd6777029231 * 64'd16777216 + 64'd5000000) / 64'd10000000) << 16);

  localparam logic [ACC_W-1:0] ROUND_Q40 = ACC_W'(64'd1 << 39);
  localparam logic [MV_W-1:0]  MV_MAX    = MV_W'(4200);

  // charge level: (mv - 3000) * 65536 / 700, rounded
  localparam logic [MV_W-1:0]  MV_EMPTY  = MV_W'(3000);
  localparam logic [MV_W-1:0]  MV_FULL   = MV_W'(3700);
  localparam int               D_W       = 10;
  localparam int               X_W       = D_W + 16;
  localparam logic [15:0]      LVL_BIAS  = 16'd350;
  localparam logic [X_W:0]     LVL_DIV   = (X_W + 1)'(700);
  localparam int               RECIP_SH  = 40;
  localparam int               RECIP_W   = 31;
  localparam logic [RECIP_W-1:0] LVL_RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'd700);
  localparam logic [LVL_W-1:0] LVL_ONE   = LVL_W'(65536);

  // delay from an accepted start to its done strobe
  localparam int LATENCY = 7;

  typedef enum logic [1:0] {
    SEG_LOW  = 2'd0,
    SEG_QUAD = 2'd1,
    SEG_HIGH = 2'd2
  } seg_t;

  typedef struct packed {
    logic           valid;
    logic [V_W-1:0] v;
  } volt_stage_t;

  typedef struct packed {
    logic            valid;
    logic [MV_W-1:0] mv;
  } mv_stage_t;

endpackage

// File: rtl/core/battery_voltage_level_calibrator_top.sv
// ----------------------------------------------------------------------------
// battery_voltage_level_calibrator_top
// Raw battery adc sample to calibrated millivolts, charge level and flags.
// ----------------------------------------------------------------------------
// usage
//   command channel: drive adc_sample and raise start; the sample transfers
//   at a rising edge where start is high and busy is low. busy is always low,
//   so a new sample can transfer on every cycle.
//   result channel: done is high for exactly one cycle with battery_mv,
//   charge_level, is_empty, is_full and is_critical; that cycle is the
//   transfer. the receiver cannot stall, so results must be taken as shown.
//   throughput is one result per cycle, through the seven-stage pipeline
//   (scale multiply, segment multiply, square term, accumulate, round and
//   clamp, reciprocal multiply, correction and flags).
//   config: wr_en with wr_index and wr_data writes a register at the edge;
//   index 0 is resolution_mv_per_lsb (Q8.16), index 1 is critical_level
//   (Q1.16, low 17 bits of wr_data). write only while the pipeline is empty.
//   reset: rst clears all stage valid bits, so done stays low until samples
//   arrive, and loads the register reset values.
// ----------------------------------------------------------------------------
module battery_voltage_level_calibrator_top (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [bvlc_pkg::SAMPLE_BITS-1:0]  adc_sample,
  // config write port
  input  logic                              wr_en,
  input  logic                              wr_index,
  input  logic [bvlc_pkg::WDATA_W-1:0]      wr_data,
  // result channel
  output logic                              done,
  output logic [bvlc_pkg::MV_W-1:0]         battery_mv,
  output logic [bvlc_pkg::LVL_W-1:0]        charge_level,
  output logic                              is_empty,
  output logic                              is_full,
  output logic                              is_critical
);
  import bvlc_pkg::*;

  logic [RES_W-1:0] resolution_mv_per_lsb;
  logic [LVL_W-1:0] critical_level;
  volt_stage_t      volt;
  mv_stage_t        mv_stage;

  // fully pipelined, never refuses a transfer
  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution_mv_per_lsb <= RESOLUTION_RST;
      critical_level        <= CRITICAL_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_RESOLUTION: resolution_mv_per_lsb <= wr_data[RES_W-1:0];
        REG_CRITICAL:   critical_level        <= wr_data[LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage 1: sample times resolution
  bvlc_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .sample     (adc_sample),
    .resolution (resolution_mv_per_lsb),
    .volt       (volt)
  );

  // stages 2-5: segment calibration, round and clamp
  bvlc_calib u_calib (
    .clk    (clk),
    .rst    (rst),
    .volt   (volt),
    .mv_out (mv_stage)
  );

  // stages 6-7: charge level and flags
  bvlc_level u_level (
    .clk            (clk),
    .rst            (rst),
    .mv_in          (mv_stage),
    .critical_level (critical_level),
    .done           (done),
    .battery_mv     (battery_mv),
    .charge_level   (charge_level),
    .is_empty       (is_empty),
    .is_full        (is_full),
    .is_critical    (is_critical)
  );

endmodule

// File: rtl/core/bvlc_scale.sv
// ----------------------------------------------------------------------------
// bvlc_scale
// Stage 1: raw sample times resolution gives the adc voltage in Q16 mV.
// ----------------------------------------------------------------------------
module bvlc_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [bvlc_pkg::SAMPLE_BITS-1:0]  sample,
  input  logic [bvlc_pkg::RES_W-1:0]        resolution,
  output bvlc_pkg::volt_stage_t             volt
);
  import bvlc_pkg::*;

  always_ff @(posedge clk) begin
    volt.v <= V_W'(sample) * V_W'(resolution);
    if (rst) begin
      volt.valid <= 1'b0;
    end else begin
      volt.valid <= in_valid;
    end
  end

endmodule

// File: rtl/core/bvlc_calib.sv
// ----------------------------------------------------------------------------
// bvlc_calib
// Stages 2 to 5: three-segment calibration to whole millivolts, clamped.
// ----------------------------------------------------------------------------
module bvlc_calib (
  input  logic                   clk,
  input  logic                   rst,
  input  bvlc_pkg::volt_stage_t  volt,
  output bvlc_pkg::mv_stage_t    mv_out
);
  import bvlc_pkg::*;

  // stage 2 signals
  seg_t              seg_c;
  logic [VOP_W-1:0]  vop_c;
  logic [GAIN_W-1:0] gain_c;
  logic [2*VSQ_W-1:0] sq_full_c;
  logic              s2_valid;
  seg_t              s2_seg;
  logic [LIN_W-1:0]  s2_lin;
  logic [SQ_W-1:0]   s2_sq;

  // stage 3 signals
  logic [ACC_W-1:0]  part_c;
  logic              s3_valid;
  seg_t              s3_seg;
  logic [ACC_W-1:0]  s3_part;
  logic [SQT_W-1:0]  s3_sqt;

  // stage 4 signals
  logic [ACC_W-1:0]  acc_c;
  logic              s4_valid;
  logic [ACC_W-1:0]  s4_acc;

  // stage 5 signals
  logic [ACC_W-1:0]  rnd_c;
  logic [ACC_W-41:0] mv_wide_c;
  logic [MV_W-1:0]   mv_c;

  // segment select and operand saturation
  always_comb begin
    if (volt.v < SEG_LO_Q16) begin
      seg_c  = SEG_LOW;
      vop_c  = volt.v[VOP_W-1:0];
      gain_c = K1_GAIN;
    end else if (volt.v <= SEG_HI_Q16) begin
      seg_c  = SEG_QUAD;
      vop_c  = volt.v[VOP_W-1:0];
      gain_c = K2_LIN;
    end else begin
      seg_c  = SEG_HIGH;
      vop_c  = (volt.v > V_SAT_Q16) ? V_SAT_Q16[VOP_W-1:0] : volt.v[VOP_W-1:0];
      gain_c = K3_GAIN;
    end
  end

  assign sq_full_c = volt.v[VSQ_W-1:0] * volt.v[VSQ_W-1:0];

  always_ff @(posedge clk) begin
    s2_seg <= seg_c;
    s2_lin <= LIN_W'(gain_c) * LIN_W'(vop_c);
    s2_sq  <= sq_full_c[2*VSQ_W-1:16];
  end

  // offset add and square term
  always_comb begin
    case (s2_seg)
      SEG_LOW:  part_c = ACC_W'(s2_lin) + ACC_W'(K1_OFF_Q40);
      SEG_QUAD: part_c = ACC_W'(s2_lin) - ACC_W'(K2_OFF_Q40);
      SEG_HIGH: part_c = ACC_W'(s2_lin) + ACC_W'(K3_OFF_Q40);
      default:  part_c = ACC_W'(s2_lin);
    endcase
  end

  always_ff @(posedge clk) begin
    s3_seg  <= s2_seg;
    s3_part <= part_c;
    s3_sqt  <= SQT_W'(K2_SQ) * SQT_W'(s2_sq);
  end

  assign acc_c = (s3_seg == SEG_QUAD) ? (s3_part - ACC_W'(s3_sqt)) : s3_part;

  always_ff @(posedge clk) begin
    s4_acc <= acc_c;
  end

  // round half up to mV, negative to zero, clamp
  assign rnd_c     = s4_acc + ROUND_Q40;
  assign mv_wide_c = rnd_c[ACC_W-1:40];

  always_comb begin
    if (s4_acc[ACC_W-1] || (s4_acc == '0)) begin
      mv_c = '0;
    end else if (mv_wide_c > (ACC_W-40)'(MV_MAX)) begin
      mv_c = MV_MAX;
    end else begin
      mv_c = mv_wide_c[MV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    mv_out.mv <= mv_c;
    if (rst) begin
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      mv_out.valid <= 1'b0;
    end else begin
      s2_valid     <= volt.valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      mv_out.valid <= s4_valid;
    end
  end

endmodule

// File: rtl/core/bvlc_level.sv
// ----------------------------------------------------------------------------
// bvlc_level
// Stages 6 and 7: charge level by reciprocal multiply with one correction
// step, flags and the registered result.
// ----------------------------------------------------------------------------
module bvlc_level (
  input  logic                         clk,
  input  logic                         rst,
  input  bvlc_pkg::mv_stage_t          mv_in,
  input  logic [bvlc_pkg::LVL_W-1:0]   critical_level,
  output logic                         done,
  output logic [bvlc_pkg::MV_W-1:0]    battery_mv,
  output logic [bvlc_pkg::LVL_W-1:0]   charge_level,
  output logic                         is_empty,
  output logic                         is_full,
  output logic                         is_critical
);
  import bvlc_pkg::*;

  logic [MV_W-1:0]            d_wide_c;
  logic [X_W-1:0]             x_c;
  logic [X_W+RECIP_W-1:0]     prod_c;

  logic                       s6_valid;
  logic [MV_W-1:0]            s6_mv;
  logic                       s6_zero;
  logic                       s6_one;
  logic [X_W-1:0]             s6_x;
  logic [LVL_W-1:0]           s6_q;

  logic [X_W:0]               rem_c;
  logic [LVL_W-1:0]           q_c;
  logic [LVL_W-1:0]           lvl_c;

  assign d_wide_c = mv_in.mv - MV_EMPTY;
  assign x_c      = {d_wide_c[D_W-1:0], LVL_BIAS};
  assign prod_c   = (X_W + RECIP_W)'(x_c) * (X_W + RECIP_W)'(LVL_RECIP);

  always_ff @(posedge clk) begin
    s6_mv   <= mv_in.mv;
    s6_zero <= (mv_in.mv <= MV_EMPTY);
    s6_one  <= (mv_in.mv >= MV_FULL);
    s6_x    <= x_c;
    s6_q    <= prod_c[RECIP_SH +: LVL_W];
  end

  // estimate is low by at most one
  assign rem_c = (X_W + 1)'(s6_x) - (X_W + 1)'(s6_q) * LVL_DIV;
  assign q_c   = (rem_c >= LVL_DIV) ? (s6_q + LVL_W'(1)) : s6_q;

  always_comb begin
    if (s6_zero) begin
      lvl_c = '0;
    end else if (s6_one) begin
      lvl_c = LVL_ONE;
    end else begin
      lvl_c = q_c;
    end
  end

  always_ff @(posedge clk) begin
    battery_mv   <= s6_mv;
    charge_level <= lvl_c;
    is_empty     <= (lvl_c == '0);
    is_full      <= (lvl_c >= LVL_ONE);
    is_critical  <= (lvl_c <= critical_level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s6_valid <= mv_in.valid;
      done     <= s6_valid;
    end
  end

endmodule

// File: rtl/core/bvlc_checker.sv
// ----------------------------------------------------------------------------
// bvlc_checker
// Port-level checks on result timing and on consistency of result fields.
// ----------------------------------------------------------------------------
module bvlc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              done,
  input  logic [bvlc_pkg::MV_W-1:0]         battery_mv,
  input  logic [bvlc_pkg::LVL_W-1:0]        charge_level,
  input  logic                              is_empty,
  input  logic                              is_full
);
  import bvlc_pkg::*;

  // every transfer gives exactly one result at fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("no result after sample transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, LATENCY))
    else $error("result without sample transfer");

  a_mv_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (battery_mv <= MV_MAX && charge_level <= LVL_ONE))
    else $error("result out of range");

  a_empty_mv: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (battery_mv <= MV_EMPTY)))
    else $error("empty flag disagrees with voltage");

  a_full_mv: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_full == (battery_mv >= MV_FULL)))
    else $error("full flag disagrees with voltage");

endmodule

bind battery_voltage_level_calibrator_top bvlc_checker u_bvlc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .battery_mv   (battery_mv),
  .charge_level (charge_level),
  .is_empty     (is_empty),
  .is_full      (is_full)
);
